/* hdl/binary_payload_length_checker_macros.svh */
// Assertion macros shared by the payload length checker RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BINARY_PAYLOAD_LENGTH_CHECKER_MACROS_SVH
`define BINARY_PAYLOAD_LENGTH_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPLC_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPLC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bplc_pkg.sv */
// Types, codes and constants for the binary payload length checker.
// No dependencies; imported by bplc_parser and the top level.
package bplc_pkg;

    localparam int DATA_W       = 8;
    localparam int FIELD_IDX_W  = 4;
    localparam int DESC_W       = 5;
    localparam int DESC_REG_W   = 60;
    localparam int COUNT_W      = 4;
    localparam int MAX_FIELDS_DEF = 12;
    localparam int LEN_W        = 32;
    localparam int SKIP_W       = 35;
    localparam int STATUS_W     = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = DESC_REG_W;
    localparam int OUT_FIELDS_W = STATUS_W + FIELD_IDX_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIELD_COUNT = 1'b0,
        CFG_DESCRIPTORS = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        KIND_PRIM  = 3'd0,
        KIND_STR   = 3'd1,
        KIND_LISTP = 3'd2,
        KIND_LISTS = 3'd3,
        KIND_SETP  = 3'd4,
        KIND_SETS  = 3'd5,
        KIND_MAPSP = 3'd6,
        KIND_MAPSS = 3'd7
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_STR_LEN   = 3'd1,
        ST_STR_BODY  = 3'd2,
        ST_COUNT     = 3'd3,
        ST_ITEMS     = 3'd4,
        ST_MAP_VALUE = 3'd5,
        ST_PRIM      = 3'd6
    } status_t;

    typedef enum logic [6:0] {
        PH_FIELD   = 7'b0000001,
        PH_PRIM    = 7'b0000010,
        PH_STRLEN  = 7'b0000100,
        PH_STRBODY = 7'b0001000,
        PH_COUNT   = 7'b0010000,
        PH_ITEMS   = 7'b0100000,
        PH_MAPVAL  = 7'b1000000
    } phase_t;

    typedef struct packed {
        status_t                  status;
        logic [FIELD_IDX_W-1:0]   error_field;
    } result_t;

    // log2 of the primitive size in bytes: 1, 4, 8 (code three is 8)
    function automatic logic [1:0] size_shift(input logic [1:0] code);
        logic [1:0] s;
        case (code)
            2'd0:    s = 2'd0;
            2'd1:    s = 2'd2;
            default: s = 2'd3;
        endcase
        return s;
    endfunction

endpackage

/* hdl/bplc_parser.sv */
// Per-byte schema walker: parse state registers and next-state logic.
// Depends on bplc_pkg and binary_payload_length_checker_macros.svh.
`include "binary_payload_length_checker_macros.svh"
module bplc_parser #(
    parameter int MAX_FIELDS = bplc_pkg::MAX_FIELDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                take,
    input  logic [bplc_pkg::DATA_W-1:0]         data_byte,
    input  logic                                has_byte,
    input  logic                                last,
    input  logic [bplc_pkg::FIELD_IDX_W-1:0]    field_limit,
    input  logic [bplc_pkg::DESC_W*MAX_FIELDS-1:0] descriptors,
    output bplc_pkg::result_t                   result
);
    import bplc_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [FIELD_IDX_W-1:0] fidx_reg, fidx_next;
    logic [1:0]             hdr_reg, hdr_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [SKIP_W-1:0]      skip_reg, skip_next;
    logic [LEN_W-1:0]       elem_reg, elem_next;
    logic                   mval_reg, mval_next;
    logic                   done_reg, done_next;

    phase_t                 ph;
    logic [FIELD_IDX_W-1:0] fi;
    logic [1:0]             hb;
    logic [LEN_W-1:0]       la;
    logic [SKIP_W-1:0]      sk;
    logic [LEN_W-1:0]       el;
    logic                   mvh;
    logic                   sd;
    logic                   do_str, do_cnt, do_elem, do_field;
    logic [DESC_W-1:0]      desc_cur, desc_end;
    kind_t                  kind_cur, kind_end;
    logic [1:0]             shift_cur;
    logic [SKIP_W-1:0]      size_cur;
    status_t                st;
    logic                   skip_phase;

    function automatic logic [DESC_W-1:0] desc_at(
        input logic [DESC_W*MAX_FIELDS-1:0] descs,
        input logic [FIELD_IDX_W-1:0]       idx
    );
        logic [DESC_W-1:0] d;
        d = '0;
        for (int i = 0; i < MAX_FIELDS; i++)
        begin
            if (idx == FIELD_IDX_W'(i))
            begin
                d = descs[DESC_W*i +: DESC_W];
            end
        end
        return d;
    endfunction

    assign desc_cur  = desc_at(descriptors, fidx_reg);
    assign kind_cur  = kind_t'(desc_cur[2:0]);
    assign shift_cur = size_shift(desc_cur[4:3]);
    assign size_cur  = SKIP_W'(1) << shift_cur;

    always_comb
    begin
        ph       = phase_reg;
        fi       = fidx_reg;
        hb       = hdr_reg;
        la       = len_reg;
        sk       = skip_reg;
        el       = elem_reg;
        mvh      = mval_reg;
        sd       = done_reg;
        do_str   = 1'b0;
        do_cnt   = 1'b0;
        do_elem  = 1'b0;
        do_field = 1'b0;

        if (has_byte && !sd)
        begin
            if (ph == PH_FIELD)
            begin
                if (fi >= field_limit)
                begin
                    sd = 1'b1;
                end
                else
                begin
                    hb  = '0;
                    la  = '0;
                    mvh = 1'b0;
                    case (kind_cur)
                        KIND_PRIM:
                        begin
                            ph = PH_PRIM;
                            sk = size_cur;
                        end
                        KIND_STR: ph = PH_STRLEN;
                        default:  ph = PH_COUNT;
                    endcase
                end
            end
            if (!sd)
            begin
                case (ph)
                    PH_PRIM, PH_ITEMS:
                    begin
                        if (sk <= SKIP_W'(1))
                        begin
                            sk       = '0;
                            do_field = 1'b1;
                        end
                        else
                        begin
                            sk = sk - SKIP_W'(1);
                        end
                    end
                    PH_STRLEN:
                    begin
                        la[{hb[0], 3'b000} +: 8] = la[{hb[0], 3'b000} +: 8] | data_byte;
                        if (hb != 2'd0)
                        begin
                            hb = '0;
                            sk = SKIP_W'(la[15:0]);
                            if (la[15:0] == 16'd0)
                            begin
                                do_str = 1'b1;
                            end
                            else
                            begin
                                ph = PH_STRBODY;
                            end
                        end
                        else
                        begin
                            hb = 2'd1;
                        end
                    end
                    PH_STRBODY:
                    begin
                        if (sk <= SKIP_W'(1))
                        begin
                            sk     = '0;
                            do_str = 1'b1;
                        end
                        else
                        begin
                            sk = sk - SKIP_W'(1);
                        end
                    end
                    PH_COUNT:
                    begin
                        la[{hb, 3'b000} +: 8] = la[{hb, 3'b000} +: 8] | data_byte;
                        if (hb == 2'd3)
                        begin
                            do_cnt = 1'b1;
                        end
                        else
                        begin
                            hb = hb + 2'd1;
                        end
                    end
                    PH_MAPVAL:
                    begin
                        if (sk <= SKIP_W'(1))
                        begin
                            sk      = '0;
                            do_elem = 1'b1;
                        end
                        else
                        begin
                            sk = sk - SKIP_W'(1);
                        end
                    end
                    default: ph = PH_FIELD;
                endcase
            end
        end

        if (do_cnt)
        begin
            el  = la;
            hb  = '0;
            mvh = 1'b0;
            if (kind_cur == KIND_LISTP || kind_cur == KIND_SETP || kind_cur == KIND_PRIM)
            begin
                sk = SKIP_W'(la) << shift_cur;
                if (la == '0)
                begin
                    do_field = 1'b1;
                end
                else
                begin
                    ph = PH_ITEMS;
                end
            end
            else if (la == '0)
            begin
                do_field = 1'b1;
            end
            else
            begin
                ph = PH_STRLEN;
                la = '0;
            end
        end

        if (do_str)
        begin
            if (kind_cur == KIND_STR || kind_cur == KIND_PRIM)
            begin
                do_field = 1'b1;
            end
            else if (kind_cur == KIND_MAPSS && !mvh)
            begin
                mvh = 1'b1;
                ph  = PH_STRLEN;
                hb  = '0;
                la  = '0;
            end
            else if (kind_cur == KIND_MAPSP)
            begin
                ph = PH_MAPVAL;
                sk = size_cur;
            end
            else
            begin
                do_elem = 1'b1;
            end
        end

        if (do_elem)
        begin
            mvh = 1'b0;
            if (el != '0)
            begin
                el = el - LEN_W'(1);
            end
            if (el == '0)
            begin
                do_field = 1'b1;
            end
            else
            begin
                ph = PH_STRLEN;
                hb = '0;
                la = '0;
            end
        end

        if (do_field)
        begin
            fi  = fi + FIELD_IDX_W'(1);
            ph  = PH_FIELD;
            hb  = '0;
            mvh = 1'b0;
        end
    end

    // end-of-payload status from the state after this byte
    assign desc_end = desc_at(descriptors, fi);
    assign kind_end = kind_t'(desc_end[2:0]);

    always_comb
    begin
        st = ST_OK;
        if (!sd)
        begin
            case (ph)
                PH_FIELD:
                begin
                    if (fi < field_limit)
                    begin
                        case (kind_end)
                            KIND_PRIM: st = ST_PRIM;
                            KIND_STR:  st = ST_STR_LEN;
                            default:   st = ST_COUNT;
                        endcase
                    end
                end
                PH_PRIM:    st = ST_PRIM;
                PH_STRLEN:  st = ST_STR_LEN;
                PH_STRBODY: st = ST_STR_BODY;
                PH_COUNT:   st = ST_COUNT;
                PH_ITEMS:   st = ST_ITEMS;
                PH_MAPVAL:  st = ST_MAP_VALUE;
                default:    st = ST_OK;
            endcase
        end
        result.status      = st;
        result.error_field = (st == ST_OK) ? '0 : fi;
    end

    always_comb
    begin
        phase_next = phase_reg;
        fidx_next  = fidx_reg;
        hdr_next   = hdr_reg;
        len_next   = len_reg;
        skip_next  = skip_reg;
        elem_next  = elem_reg;
        mval_next  = mval_reg;
        done_next  = done_reg;
        if (take)
        begin
            if (last)
            begin
                phase_next = PH_FIELD;
                fidx_next  = '0;
                hdr_next   = '0;
                len_next   = '0;
                skip_next  = '0;
                elem_next  = '0;
                mval_next  = 1'b0;
                done_next  = 1'b0;
            end
            else
            begin
                phase_next = ph;
                fidx_next  = fi;
                hdr_next   = hb;
                len_next   = la;
                skip_next  = sk;
                elem_next  = el;
                mval_next  = mvh;
                done_next  = sd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIELD;
            fidx_reg  <= '0;
            hdr_reg   <= '0;
            len_reg   <= '0;
            skip_reg  <= '0;
            elem_reg  <= '0;
            mval_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            fidx_reg  <= fidx_next;
            hdr_reg   <= hdr_next;
            len_reg   <= len_next;
            skip_reg  <= skip_next;
            elem_reg  <= elem_next;
            mval_reg  <= mval_next;
            done_reg  <= done_next;
        end
    end

    assign skip_phase = (phase_reg == PH_PRIM) || (phase_reg == PH_ITEMS) ||
                        (phase_reg == PH_STRBODY) || (phase_reg == PH_MAPVAL);

    `BPLC_ASSERT_SAME(a_done_in_field_phase, clk, rst_n, done_reg, phase_reg == PH_FIELD, "schema done outside field phase")
    `BPLC_ASSERT_SAME(a_skip_nonzero, clk, rst_n, skip_phase, skip_reg != '0, "skip phase with zero bytes left")

endmodule

/* hdl/binary_payload_length_checker.sv */
// Binary payload length checker: one payload byte per request, truncation check.
// A request with tlast gives its result on m_axis in the cycle after acceptance.
// Throughput: one request per cycle; the output register stalls input only while full.
// Reset (rst_n, async, active low) clears config, parse state and output valid.
// Depends on bplc_pkg, bplc_parser and binary_payload_length_checker_macros.svh.
`include "binary_payload_length_checker_macros.svh"
module binary_payload_length_checker #(
    parameter int MAX_FIELDS = bplc_pkg::MAX_FIELDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bplc_pkg::DATA_W-1:0]         s_axis_tdata,   // data_byte
    input  logic                                s_axis_tuser,   // has_byte
    input  logic                                s_axis_tlast,   // last
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bplc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // status, error_field, zero pad
    input  logic                                cfg_we,
    input  logic [bplc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bplc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bplc_pkg::*;

    localparam logic [FIELD_IDX_W-1:0] MAX_FIELDS_V = FIELD_IDX_W'(MAX_FIELDS);

    logic [COUNT_W-1:0]           fcount_reg;
    logic [DESC_W*MAX_FIELDS-1:0] desc_reg;
    logic [FIELD_IDX_W-1:0]       field_limit;
    logic                         take;
    result_t                      result;
    result_t                      out_reg;
    logic                         out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcount_reg <= '0;
            desc_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_FIELD_COUNT: fcount_reg <= cfg_data[COUNT_W-1:0];
                CFG_DESCRIPTORS: desc_reg   <= cfg_data[DESC_W*MAX_FIELDS-1:0];
                default:         fcount_reg <= fcount_reg;
            endcase
        end
    end

    assign field_limit   = (fcount_reg > MAX_FIELDS_V) ? MAX_FIELDS_V : fcount_reg;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;

    bplc_parser #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .data_byte   (s_axis_tdata),
        .has_byte    (s_axis_tuser),
        .last        (s_axis_tlast),
        .field_limit (field_limit),
        .descriptors (desc_reg),
        .result      (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && s_axis_tlast)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && s_axis_tlast)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.error_field, out_reg.status};

    `BPLC_ASSERT_NEXT(a_last_gives_result, clk, rst_n, take && s_axis_tlast, m_axis_tvalid, "no result after end of payload")
    `BPLC_ASSERT_SAME(a_ok_field_zero, clk, rst_n, m_axis_tvalid && out_reg.status == ST_OK, out_reg.error_field == '0, "ok status with nonzero field index")
    `BPLC_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, !s_axis_tready, m_axis_tvalid, "input stalled with empty output register")

endmodule
